// ===== rtl/core/jmws_pkg.sv =====
package jmws_pkg;

  // Event kinds carried on the result tuser
  typedef enum logic [2:0] {
    EV_MARKER  = 3'd0,
    EV_SPLIT   = 3'd1,
    EV_UNKNOWN = 3'd2,
    EV_TRUNC   = 3'd3,
    EV_BADLEN  = 3'd4
  } jmws_event_e;

  // Marker bytes of interest
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] CODE_MIN  = 8'hC0;
  localparam logic [7:0] CODE_SOI  = 8'hD8;
  localparam logic [7:0] CODE_EOI  = 8'hD9;
  localparam logic [7:0] CODE_SOS  = 8'hDA;

  localparam int unsigned IMG_NUM_W = 16;
  localparam int unsigned SEG_LEN_W = 16;
  localparam int unsigned OUT_OFF_W = 32;

  // Record passed from the walker to the output stage (offset travels beside it)
  typedef struct packed {
    logic                 restart;   // walk was restarted since the previous record
    jmws_event_e          kind;
    logic [7:0]           code;
    logic [SEG_LEN_W-1:0] seg_len;
  } jmws_rec_t;

  localparam int unsigned REC_W = $bits(jmws_rec_t);

endpackage

// ===== rtl/core/jpeg_marker_walker_splitter_unit.sv =====
// The record of a byte is written into the queue at the edge that takes the byte, and moves on
// into the output register once that register is empty or its record is being taken.
// Throughput: one byte per cycle; the walker takes a byte whenever the 4-entry queue has room.
// Reset (rst_ni low, asynchronous): walk expects an FF byte, offsets and image count clear,
// queue and output register empty.
module jpeg_marker_walker_splitter_unit import jmws_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] first_of_file
  input  logic         s_axis_tlast,   // last_of_file
  // event records
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // [7:0] marker_code, [39:8] marker_offset,
                                       // [55:40] segment_length, [87:56] image_start,
                                       // [119:88] image_end, [135:120] image_number
  output logic [2:0]   m_axis_tuser    // [2:0] event_kind
);

  localparam int unsigned Q_W = REC_W + OFFSET_BITS;

  logic                   acc;
  logic                   push;
  jmws_rec_t              f_rec, b_rec;
  logic [OFFSET_BITS-1:0] f_off, b_off;
  logic [Q_W-1:0]         q_rdata;
  logic                   q_empty, q_full, pop;

  assign s_axis_tready = ~q_full;
  assign acc           = s_axis_tvalid & ~q_full;

  jmws_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .byte_i  (s_axis_tdata),
    .first_i (s_axis_tuser),
    .last_i  (s_axis_tlast),
    .push_o  (push),
    .rec_o   (f_rec),
    .off_o   (f_off)
  );

  jmws_queue #(.DATA_W(Q_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_rec, f_off}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign b_rec = q_rdata[Q_W-1:OFFSET_BITS];
  assign b_off = q_rdata[OFFSET_BITS-1:0];

  jmws_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (~q_empty),
    .rec_i   (b_rec),
    .off_i   (b_off),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .kind_o  (m_axis_tuser),
    .data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/jmws_front.sv =====
module jmws_front import jmws_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte transaction
  input  logic                   acc_i,
  input  logic [7:0]             byte_i,
  input  logic                   first_i,
  input  logic                   last_i,
  // record towards the queue
  output logic                   push_o,
  output jmws_rec_t              rec_o,
  output logic [OFFSET_BITS-1:0] off_o
);

  // Walk phases
  localparam logic [2:0] PH_FF   = 3'd0;
  localparam logic [2:0] PH_CODE = 3'd1;
  localparam logic [2:0] PH_LENH = 3'd2;
  localparam logic [2:0] PH_LENL = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_SCAN = 3'd5;

  logic [2:0]             phase_q, phase_d;
  logic [7:0]             prev_q, prev_d;
  logic [7:0]             cur_q, cur_d;
  logic [7:0]             lenh_q, lenh_d;
  logic [15:0]            skip_q, skip_d;
  logic [OFFSET_BITS-1:0] ofs_q, ofs_d;
  logic [OFFSET_BITS-1:0] mstart_q, mstart_d;
  logic                   halted_q, halted_d;
  logic                   pend_q, pend_d;

  logic                   emit;
  logic                   stop;
  logic [15:0]            len;
  logic [2:0]             after_ph;
  logic                   after_scan;
  jmws_rec_t              rec;
  logic [OFFSET_BITS-1:0] rec_off;

  // Next state of the walk for the byte of this transaction
  always_comb begin
    phase_d  = phase_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    lenh_d   = lenh_q;
    skip_d   = skip_q;
    ofs_d    = ofs_q;
    mstart_d = mstart_q;
    halted_d = halted_q;
    pend_d   = pend_q;
    emit     = 1'b0;
    stop     = 1'b0;
    len      = {lenh_q, byte_i};
    rec      = '{restart: 1'b0, kind: EV_MARKER, code: 8'h00, seg_len: '0};
    rec_off  = mstart_q;

    // restart clears the walk before the byte is taken
    if (first_i) begin
      phase_d  = PH_FF;
      prev_d   = 8'h00;
      cur_d    = 8'h00;
      lenh_d   = 8'h00;
      skip_d   = 16'h0000;
      ofs_d    = '0;
      mstart_d = '0;
      halted_d = 1'b0;
      pend_d   = 1'b1;
      len      = {8'h00, byte_i};
    end

    after_scan = (cur_d == CODE_SOS);
    after_ph   = after_scan ? PH_SCAN : PH_FF;

    if (!halted_d) begin
      unique case (phase_d)
        PH_FF: begin
          if (byte_i != BYTE_FF) begin
            emit     = 1'b1;
            stop     = 1'b1;
            rec.kind = EV_UNKNOWN;
            rec.code = byte_i;
            rec_off  = ofs_d;
          end else begin
            mstart_d = ofs_d;
            cur_d    = 8'h00;
            phase_d  = PH_CODE;
          end
        end
        PH_CODE: begin
          if (byte_i < CODE_MIN) begin
            emit     = 1'b1;
            stop     = 1'b1;
            rec.kind = EV_UNKNOWN;
            rec.code = byte_i;
            rec_off  = mstart_d;
          end else begin
            cur_d = byte_i;
            if (byte_i == CODE_SOI) begin
              emit     = 1'b1;
              rec.kind = EV_MARKER;
              rec.code = byte_i;
              rec_off  = mstart_d;
              phase_d  = PH_FF;
            end else if (byte_i == CODE_EOI) begin
              emit     = 1'b1;
              rec.kind = EV_SPLIT;
              rec.code = CODE_EOI;
              rec_off  = mstart_d;
              phase_d  = PH_FF;
            end else begin
              phase_d = PH_LENH;
            end
          end
        end
        PH_LENH: begin
          lenh_d  = byte_i;
          phase_d = PH_LENL;
        end
        PH_LENL: begin
          emit        = 1'b1;
          rec.code    = cur_d;
          rec.seg_len = len;
          rec_off     = mstart_d;
          if (len < 16'd2) begin
            stop     = 1'b1;
            rec.kind = EV_BADLEN;
          end else begin
            rec.kind = EV_MARKER;
            skip_d   = len - 16'd2;
            if (len != 16'd2) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d = after_ph;
              if (after_scan) prev_d = 8'h00;
            end
          end
        end
        PH_SKIP: begin
          skip_d = skip_d - 16'd1;
          if (skip_d == 16'd0) begin
            phase_d = after_ph;
            if (after_scan) prev_d = 8'h00;
          end
        end
        PH_SCAN: begin
          if (prev_d == BYTE_FF && byte_i == CODE_EOI) begin
            mstart_d = ofs_d - OFFSET_BITS'(1);
            cur_d    = CODE_EOI;
            emit     = 1'b1;
            rec.kind = EV_SPLIT;
            rec.code = CODE_EOI;
            rec_off  = mstart_d;
            phase_d  = PH_FF;
          end
          prev_d = byte_i;
        end
        default: begin
          phase_d = PH_FF;
        end
      endcase

      if (stop) begin
        halted_d = 1'b1;
      end else begin
        // end of file: halt, flag an open structure
        if (last_i) begin
          halted_d = 1'b1;
          if (phase_d != PH_FF) begin
            emit        = 1'b1;
            rec.kind    = EV_TRUNC;
            rec.code    = cur_d;
            rec.seg_len = '0;
            rec_off     = mstart_d;
          end
        end
        ofs_d = ofs_d + OFFSET_BITS'(1);
      end
    end

    rec.restart = pend_d;
    if (emit) pend_d = 1'b0;
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FF;
      prev_q   <= 8'h00;
      cur_q    <= 8'h00;
      lenh_q   <= 8'h00;
      skip_q   <= 16'h0000;
      ofs_q    <= '0;
      mstart_q <= '0;
      halted_q <= 1'b0;
      pend_q   <= 1'b0;
    end else if (acc_i) begin
      phase_q  <= phase_d;
      prev_q   <= prev_d;
      cur_q    <= cur_d;
      lenh_q   <= lenh_d;
      skip_q   <= skip_d;
      ofs_q    <= ofs_d;
      mstart_q <= mstart_d;
      halted_q <= halted_d;
      pend_q   <= pend_d;
    end
  end

  assign push_o = acc_i & emit;
  assign rec_o  = rec;
  assign off_o  = rec_off;

endmodule

// ===== rtl/core/jmws_queue.sv =====
module jmws_queue import jmws_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [PTR_W:0]    cnt_q;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + PTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + (PTR_W+1)'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - (PTR_W+1)'(1);
    end
  end

endmodule

// ===== rtl/core/jmws_back.sv =====
module jmws_back import jmws_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // from the queue
  input  logic                   avail_i,
  input  jmws_rec_t              rec_i,
  input  logic [OFFSET_BITS-1:0] off_i,
  output logic                   pop_o,
  // result transaction
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [2:0]             kind_o,
  output logic [135:0]           data_o
);

  logic                   valid_q;
  logic [2:0]             kind_q, kind_d;
  logic [135:0]           data_q, data_d;
  logic [15:0]            imgs_q, imgs_d;
  logic [OFFSET_BITS-1:0] split_q, split_d;
  logic [15:0]            imgs_base;
  logic [OFFSET_BITS-1:0] split_base;
  logic [OFFSET_BITS-1:0] end_off;
  logic [63:0]            off_x, start_x, end_x;
  logic [15:0]            num;
  logic                   is_split;

  assign pop_o = avail_i & (~valid_q | ready_i);

  // Split bookkeeping and result formatting
  always_comb begin
    imgs_base  = rec_i.restart ? 16'h0000 : imgs_q;
    split_base = rec_i.restart ? '0 : split_q;
    is_split   = (rec_i.kind == EV_SPLIT);
    end_off    = off_i + OFFSET_BITS'(2);
    num        = (imgs_base != 16'hFFFF) ? imgs_base + 16'd1 : imgs_base;
    off_x      = 64'(off_i);
    start_x    = is_split ? 64'(split_base) : 64'h0;
    end_x      = is_split ? 64'(end_off) : 64'h0;
    imgs_d     = is_split ? num : imgs_base;
    split_d    = is_split ? end_off : split_base;
    kind_d     = rec_i.kind;
    data_d     = {is_split ? num : 16'h0000, end_x[31:0], start_x[31:0],
                  rec_i.seg_len, off_x[31:0], rec_i.code};
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= kind_d;
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      imgs_q  <= 16'h0000;
      split_q <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        imgs_q  <= imgs_d;
        split_q <= split_d;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/jmws_checker.sv =====
module jmws_checker import jmws_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  // a stalled record holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // split records name EOI and a non-zero image index
  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_SPLIT |->
      m_axis_tdata[7:0] == CODE_EOI && m_axis_tdata[135:120] != 16'h0000
      && m_axis_tdata[55:40] == 16'h0000)
    else $error("malformed split record");

  // other records carry no image bounds
  a_nosplit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EV_SPLIT |->
      m_axis_tdata[135:56] == '0)
    else $error("image fields set outside a split record");

  // no result appears without a byte having gone in beforehand
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2)
      || $past(m_axis_tvalid, 1) || !$past(s_axis_tready, 1)
      || !$past(s_axis_tready, 2))
    else $error("result without a preceding byte");

endmodule

bind jpeg_marker_walker_splitter_unit jmws_checker u_jmws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/jmws_walk_checker.sv =====
module jmws_walk_checker import jmws_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // byte stream, as seen by the block
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] first_of_file
  input  logic         s_axis_tlast,   // last_of_file
  // event records leaving the block
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,   // [7:0] marker_code, [39:8] marker_offset,
                                       // [55:40] segment_length, [87:56] image_start,
                                       // [119:88] image_end, [135:120] image_number
  input  logic [2:0]   m_axis_tuser,   // [2:0] event_kind
  // end of run: report anything still outstanding
  input  logic         drain_i,
  output int unsigned  fail_count_o = 0,
  output int unsigned  pending_o = 0,
  output int unsigned  records_o = 0,
  output int unsigned  splits_o = 0,
  output logic [4:0]   kinds_o = '0,
  output logic [15:0]  top_image_o = '0
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    WALK_FF,
    WALK_CODE,
    WALK_LENH,
    WALK_LENL,
    WALK_SKIP,
    WALK_SCAN
  } walk_phase_e;

  typedef struct packed {
    jmws_event_e kind;
    logic [7:0]  code;
    logic [31:0] at;
    logic [15:0] seg_len;
    logic [31:0] img_start;
    logic [31:0] img_end;
    logic [15:0] img_num;
  } walk_rec_t;

  // Predicted walker state
  walk_phase_e phase = WALK_FF;
  logic [7:0]  scan_prev = '0;
  logic [7:0]  seg_code = '0;
  logic [7:0]  len_hi = '0;
  logic [15:0] bytes_left = '0;
  logic [31:0] at_offset = '0;
  logic [31:0] marker_at = '0;
  logic [31:0] image_from = '0;
  logic [15:0] image_count = '0;
  bit          walk_stopped = 1'b0;
  bit          drained = 1'b0;

  walk_rec_t   expected_q[$];

  function automatic walk_rec_t make_rec(input jmws_event_e kind, input logic [7:0] code,
                                         input logic [31:0] at, input logic [15:0] seg_len,
                                         input logic [31:0] from, input logic [31:0] stop,
                                         input logic [15:0] num);
    walk_rec_t rec;
    rec.kind      = kind;
    rec.code      = code;
    rec.at        = at;
    rec.seg_len   = seg_len;
    rec.img_start = from;
    rec.img_end   = stop;
    rec.img_num   = num;
    return rec;
  endfunction

  task automatic restart_walk();
    phase        = WALK_FF;
    scan_prev    = '0;
    seg_code     = '0;
    len_hi       = '0;
    bytes_left   = '0;
    at_offset    = '0;
    marker_at    = '0;
    image_from   = '0;
    image_count  = '0;
    walk_stopped = 1'b0;
  endtask

  // EOI seen: image bounds run from the previous split to just past this byte
  function automatic walk_rec_t close_image();
    logic [31:0] stop;
    walk_rec_t   rec;
    stop = at_offset + 32'd1;
    if (image_count != 16'hFFFF) image_count++;
    rec = make_rec(EV_SPLIT, CODE_EOI, marker_at, '0, image_from, stop, image_count);
    image_from = stop;
    phase = WALK_FF;
    return rec;
  endfunction

  // Segment payload consumed: SOS hands over to the entropy scan
  task automatic segment_done();
    if (seg_code == CODE_SOS) begin
      scan_prev = '0;
      phase = WALK_SCAN;
    end else begin
      phase = WALK_FF;
    end
  endtask

  // One accepted byte; queues the record it causes, if any
  task automatic walk_byte(input logic [7:0] b, input logic first, input logic last);
    walk_rec_t   rec;
    bit          has_rec;
    logic [15:0] seg_len;
    has_rec = 1'b0;
    if (first) restart_walk();
    if (walk_stopped) return;
    case (phase)
      WALK_FF: begin
        if (b != BYTE_FF) begin
          expected_q = {expected_q, make_rec(EV_UNKNOWN, b, at_offset, '0, '0, '0, '0)};
          walk_stopped = 1'b1;
          return;
        end
        marker_at = at_offset;
        seg_code = '0;
        phase = WALK_CODE;
      end
      WALK_CODE: begin
        if (b < CODE_MIN) begin
          expected_q = {expected_q, make_rec(EV_UNKNOWN, b, marker_at, '0, '0, '0, '0)};
          walk_stopped = 1'b1;
          return;
        end
        seg_code = b;
        if (b == CODE_SOI) begin
          rec = make_rec(EV_MARKER, b, marker_at, '0, '0, '0, '0);
          has_rec = 1'b1;
          phase = WALK_FF;
        end else if (b == CODE_EOI) begin
          rec = close_image();
          has_rec = 1'b1;
        end else begin
          phase = WALK_LENH;
        end
      end
      WALK_LENH: begin
        len_hi = b;
        phase = WALK_LENL;
      end
      WALK_LENL: begin
        seg_len = {len_hi, b};
        if (seg_len < 16'd2) begin
          expected_q = {expected_q,
                        make_rec(EV_BADLEN, seg_code, marker_at, seg_len, '0, '0, '0)};
          walk_stopped = 1'b1;
          return;
        end
        rec = make_rec(EV_MARKER, seg_code, marker_at, seg_len, '0, '0, '0);
        has_rec = 1'b1;
        bytes_left = seg_len - 16'd2;
        if (bytes_left != 0) phase = WALK_SKIP;
        else segment_done();
      end
      WALK_SKIP: begin
        bytes_left--;
        if (bytes_left == 0) segment_done();
      end
      WALK_SCAN: begin
        if (scan_prev == BYTE_FF && b == CODE_EOI) begin
          marker_at = at_offset - 32'd1;
          seg_code = CODE_EOI;
          rec = close_image();
          has_rec = 1'b1;
        end
        scan_prev = b;
      end
      default: phase = WALK_FF;
    endcase
    // end of file: anything but a clean marker boundary is a truncation
    if (last) begin
      walk_stopped = 1'b1;
      if (phase != WALK_FF) begin
        rec = make_rec(EV_TRUNC, seg_code, marker_at, '0, '0, '0, '0);
        has_rec = 1'b1;
      end
    end
    if (has_rec) expected_q = {expected_q, rec};
    at_offset++;
  endtask

  task automatic report(input string what);
    fail_count_o++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Compare the delivered record against the oldest prediction
  task automatic check_record();
    walk_rec_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("record kind %0d code 0x%0h with nothing expected",
                       m_axis_tuser, m_axis_tdata[7:0]));
      return;
    end
    want = expected_q.pop_front();
    check_field("event_kind",     m_axis_tuser,           want.kind);
    check_field("marker_code",    m_axis_tdata[7:0],      want.code);
    check_field("marker_offset",  m_axis_tdata[39:8],     want.at);
    check_field("segment_length", m_axis_tdata[55:40],    want.seg_len);
    check_field("image_start",    m_axis_tdata[87:56],    want.img_start);
    check_field("image_end",      m_axis_tdata[119:88],   want.img_end);
    check_field("image_number",   m_axis_tdata[135:120],  want.img_num);
    records_o++;
    if (want.kind == EV_SPLIT) begin
      splits_o++;
      if (want.img_num > top_image_o) top_image_o = want.img_num;
    end
    kinds_o[want.kind] = 1'b1;
  endtask

  // Both channels sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_walk();
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_record();
      if (s_axis_tvalid && s_axis_tready) walk_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (drain_i && !drained) begin
        drained = 1'b1;
        if (expected_q.size() != 0)
          report($sformatf("%0d expected records never arrived", expected_q.size()));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  import jmws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] b;
    bit         first;
    bit         last;
  } file_byte_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         drain = 1'b0;

  int unsigned  fail_count;
  int unsigned  pending;
  int unsigned  records;
  int unsigned  splits;
  logic [4:0]   kinds;
  logic [15:0]  top_image;

  bit           calm = 1'b0;
  int unsigned  bytes_sent = 0;
  int unsigned  files_sent = 0;
  file_byte_t   file_q[$];

  always #2 clk_i = ~clk_i;

  jpeg_marker_walker_splitter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  jmws_walk_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .drain_i       (drain),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .records_o     (records),
    .splits_o      (splits),
    .kinds_o       (kinds),
    .top_image_o   (top_image)
  );

  // Record sink: stalls about a third of the time unless in a calm stretch
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready = calm || ($urandom_range(99) >= 35);
  end

  // Present one byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    while (!calm && $urandom_range(99) < 35) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = first;
    s_axis_tlast  = last;
    // tready only moves at rising edges, so its value here holds at the next one
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_byte(input logic [7:0] b);
    file_byte_t fb;
    fb.b = b;
    fb.first = 1'b0;
    fb.last = 1'b0;
    file_q = {file_q, fb};
  endtask

  // Bytes of a literal, most significant first
  task automatic put_hex(input logic [95:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) put_byte(v[8*i +: 8]);
  endtask

  task automatic put_segment(input logic [7:0] code, input logic [15:0] seg_len);
    put_byte(BYTE_FF);
    put_byte(code);
    put_byte(seg_len[15:8]);
    put_byte(seg_len[7:0]);
    for (int i = 2; i < seg_len; i++) put_byte(8'($urandom));
  endtask

  // Entropy data with plenty of stuffed FFs but no early FF D9, then EOI
  task automatic put_scan(input int n);
    logic [7:0] prev;
    logic [7:0] b;
    prev = '0;
    repeat (n) begin
      b = ($urandom_range(3) == 0) ? BYTE_FF : 8'($urandom);
      if (prev == BYTE_FF && b == CODE_EOI) b = 8'h00;
      put_byte(b);
      prev = b;
    end
    put_byte(BYTE_FF);
    put_byte(CODE_EOI);
  endtask

  function automatic logic [7:0] random_code();
    logic [7:0] c;
    do c = 8'($urandom_range(8'hC0, 8'hFF));
    while (c == CODE_SOI || c == CODE_EOI || c == CODE_SOS);
    return c;
  endfunction

  task automatic put_image();
    repeat ($urandom_range(0, 3))
      put_segment(random_code(),
                  ($urandom_range(19) == 0) ? 16'($urandom_range(2, 300))
                                            : 16'($urandom_range(2, 10)));
    if ($urandom_range(1)) begin
      put_segment(CODE_SOS, 16'($urandom_range(2, 8)));
      put_scan($urandom_range(0, 24));
    end else begin
      put_byte(BYTE_FF);
      put_byte(CODE_EOI);
    end
  endtask

  task automatic send_file(input bit with_last);
    file_q[0].first = 1'b1;
    if (with_last) file_q[file_q.size()-1].last = 1'b1;
    foreach (file_q[i]) send_byte(file_q[i].b, file_q[i].first, file_q[i].last);
    file_q.delete();
    files_sent++;
  endtask

  // Mostly a well-formed file (else a few random bytes), sometimes damaged on the way out
  task automatic send_random_file();
    int  pick;
    int  cut;
    bit  with_last;
    with_last = 1'b1;
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
    end else begin
      put_byte(BYTE_FF);
      put_byte(CODE_SOI);
      repeat ($urandom_range(1, 3)) begin
        put_image();
        if ($urandom_range(2) == 0) begin
          put_byte(BYTE_FF);
          put_byte(CODE_SOI);
        end
      end
    end
    pick = $urandom_range(99);
    if (pick >= 60 && pick < 68) begin
      file_q[$urandom_range(file_q.size() - 1)].b = 8'($urandom);
    end else if (pick >= 68 && pick < 76) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (pick >= 76 && pick < 82) begin
      with_last = 1'b0;
    end else if (pick >= 82 && pick < 88) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
    end else if (pick >= 88 && pick < 94) begin
      put_hex(96'(16'hFFE2), 2);
      put_byte(8'h00);
      put_byte(8'($urandom_range(1)));
    end else if (pick >= 94) begin
      file_q[$urandom_range(file_q.size() - 1)].first = 1'b1;
    end
    send_file(with_last);
  endtask

  // Hold the stream off until every predicted record has come out
  task automatic hold_until_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned random_from;
    int unsigned waited;
    bit          paused;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: SOI then bare EOI
    put_hex(96'(32'hFFD8FFD9), 4);
    send_file(1'b1);
    // zero-payload segment, SOS with no payload, D9 opening the scan, then EOI
    put_hex(96'(88'hFFC40002FFDA0002D9FFD9), 11);
    send_file(1'b1);
    // non-FF where a marker is due
    put_byte(8'h00);
    send_file(1'b1);
    // code below C0, trailing byte ignored while halted
    put_hex(96'(24'hFF1055), 3);
    send_file(1'b1);
    // length below two
    put_hex(96'(32'hFFE00001), 4);
    send_file(1'b1);
    // file ends inside a length field
    put_hex(96'(24'hFFE100), 3);
    send_file(1'b1);
    hold_until_drained();

    // Random files with idling on both sides
    random_from = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - random_from < 500) begin
      send_random_file();
      if (!paused && bytes_sent - random_from > 250) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    // Calm stretch: a longer segment and a few images sent with no idling at all
    calm = 1'b1;
    put_hex(96'(16'hFFD8), 2);
    put_segment(8'hFE, 16'd64);
    put_hex(96'(16'hFFD9), 2);
    put_hex(96'(32'hFFD9FFD9), 4);
    send_file(1'b1);
    calm = 1'b0;

    s_axis_tvalid = 1'b0;
    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
    drain = 1'b1;
    repeat (2) @(negedge clk_i);

    $display("Walked %0d bytes in %0d files; %0d records checked, %0d of them image splits",
             bytes_sent, files_sent, records, splits);
    $display("Event kinds seen (one bit per kind): %b; highest image index %0d",
             kinds, top_image);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
